>>> rtl/ncvd_pkg.sv
// Package for the normalized count-vector distance core.
// Types, constants and command/status structs shared by the datapath, controller and top level.
package ncvd_pkg;

    localparam int unsigned COUNT_BITS_DEF = 16;
    localparam int unsigned FIELD_BITS     = 16;
    localparam int unsigned SUM_BITS       = 64;
    localparam int unsigned DIST_BITS      = 32;

    typedef enum logic [2:0] {
        t_ST_ACC  = 3'd0,
        t_ST_MUL  = 3'd1,
        t_ST_SQRT = 3'd2,
        t_ST_DIV  = 3'd3,
        t_ST_OUT  = 3'd4
    } t_state;

    typedef enum logic {
        t_MODE_L1 = 1'b0,
        t_MODE_L2 = 1'b1
    } t_mode;

    // controller -> datapath
    typedef struct packed {
        logic acc;        // add one pair
        logic clear;      // clear sums after last pair
        logic mul_start;  // start 128-bit product
        logic sqrt_start; // start root
        logic div_start;  // start divide
        logic load_out;   // capture result into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic mul_done;
        logic sqrt_done;
        logic div_done;
        logic div_zero;   // divisor is zero
    } t_status;

endpackage

>>> rtl/ncvd_datapath.sv
// Datapath: saturating sums, serial 64x64 multiplier, bit-serial root and divider.
// Depends on ncvd_pkg.
module ncvd_datapath #(
    parameter int unsigned COUNT_BITS = ncvd_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ncvd_pkg::t_cmd                  i_cmd,
    input  logic                            i_mode,
    input  logic [ncvd_pkg::FIELD_BITS-1:0] i_count_a,
    input  logic [ncvd_pkg::FIELD_BITS-1:0] i_count_b,
    output ncvd_pkg::t_status               o_status,
    output logic [ncvd_pkg::DIST_BITS-1:0]  o_distance,
    output logic                            o_zero_divisor
);
    localparam int unsigned SB = ncvd_pkg::SUM_BITS;
    localparam int unsigned DB = ncvd_pkg::DIST_BITS;
    // counts wider than the field keep all field bits
    localparam int unsigned CB = (COUNT_BITS < ncvd_pkg::FIELD_BITS) ? COUNT_BITS
                                                                      : ncvd_pkg::FIELD_BITS;
    localparam int unsigned SQ_BITS = 2 * CB;

    logic [CB-1:0]      w_a, w_b, w_d;
    logic [SQ_BITS-1:0] w_ta, w_tb, w_td;
    logic [SB:0]        w_sd, w_sa, w_sb;

    logic [SB-1:0] r_dsum, r_asum, r_bsum;

    assign w_a = i_count_a[CB-1:0];
    assign w_b = i_count_b[CB-1:0];
    assign w_d = (w_a > w_b) ? (w_a - w_b) : (w_b - w_a);

    always_comb begin
        if (i_mode == ncvd_pkg::t_MODE_L2) begin
            w_td = SQ_BITS'(w_d) * SQ_BITS'(w_d);
            w_ta = SQ_BITS'(w_a) * SQ_BITS'(w_a);
            w_tb = SQ_BITS'(w_b) * SQ_BITS'(w_b);
        end else begin
            w_td = SQ_BITS'(w_d);
            w_ta = SQ_BITS'(w_a);
            w_tb = SQ_BITS'(w_b);
        end
        w_sd = {1'b0, r_dsum} + (SB+1)'(w_td);
        w_sa = {1'b0, r_asum} + (SB+1)'(w_ta);
        w_sb = {1'b0, r_bsum} + (SB+1)'(w_tb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_dsum <= '0;
            r_asum <= '0;
            r_bsum <= '0;
        end else if (i_cmd.acc) begin
            r_dsum <= w_sd[SB] ? '1 : w_sd[SB-1:0];
            r_asum <= w_sa[SB] ? '1 : w_sa[SB-1:0];
            r_bsum <= w_sb[SB] ? '1 : w_sb[SB-1:0];
        end
    end

    // ---- product asum*bsum: 4 partial products of 32x32, one per cycle
    logic [2*SB-1:0] r_prod;
    logic [2:0]      r_mcnt;
    logic            r_mbusy;
    logic [31:0]     w_mx, w_my;
    logic [63:0]     r_pp;
    logic [1:0]      r_ppi;
    logic            r_ppv;

    assign w_mx = r_mcnt[0] ? r_asum[63:32] : r_asum[31:0];
    assign w_my = r_mcnt[1] ? r_bsum[63:32] : r_bsum[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_ppv   <= 1'b0;
        end else if (i_cmd.mul_start) begin
            r_mbusy <= 1'b1;
            r_mcnt  <= '0;
            r_prod  <= '0;
            r_ppv   <= 1'b0;
        end else if (r_mbusy) begin
            r_ppv <= !r_mcnt[2];
            if (!r_mcnt[2]) begin
                r_pp  <= w_mx * w_my;
                r_ppi <= r_mcnt[1:0];
                r_mcnt <= r_mcnt + 3'd1;
            end
            if (r_ppv) begin
                r_prod <= r_prod
                    + ((2*SB)'(r_pp) << (32 * (32'(r_ppi[0]) + 32'(r_ppi[1]))));
            end
            // done once the last partial product has been added
            if (r_mcnt[2] && !r_ppv) r_mbusy <= 1'b0;
        end
    end
    assign o_status.mul_done = r_mbusy && r_mcnt[2] && !r_ppv;

    // ---- bit-serial root of the 128-bit product, one result bit a cycle
    logic [2*SB-1:0] r_rem;
    logic [SB-1:0]   r_root;
    logic [6:0]      r_scnt;
    logic            r_sbusy;
    logic [2*SB+1:0] w_rtrial, w_trial_sub;
    logic [2*SB+1:0] w_rem_sh;

    // restoring root: rem = rem*4 + next two bits; trial = 4*root+1
    logic [2*SB-1:0] r_rad;
    assign w_rem_sh    = {r_rem, r_rad[2*SB-1 -: 2]};
    assign w_rtrial    = {{(SB){1'b0}}, r_root, 2'b01};
    assign w_trial_sub = w_rem_sh - w_rtrial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sbusy <= 1'b0;
        end else if (i_cmd.sqrt_start) begin
            r_sbusy <= 1'b1;
            r_rad   <= r_prod;
            r_rem   <= '0;
            r_root  <= '0;
            r_scnt  <= '0;
        end else if (r_sbusy) begin
            r_rad <= r_rad << 2;
            if (w_rem_sh >= w_rtrial) begin
                r_rem  <= w_trial_sub[2*SB-1:0];
                r_root <= {r_root[SB-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh[2*SB-1:0];
                r_root <= {r_root[SB-2:0], 1'b0};
            end
            r_scnt <= r_scnt + 7'd1;
            if (r_scnt == 7'(SB-1)) r_sbusy <= 1'b0;
        end
    end
    assign o_status.sqrt_done = r_sbusy && (r_scnt == 7'(SB-1));

    // ---- divider: floor(dsum * 2^sh / div), quotient bits one a cycle
    localparam int unsigned NB = SB + 17;   // numerator bits incl. shift
    logic [SB:0]    w_div;
    logic [SB+1:0]  r_drem;
    logic [SB:0]    r_dvs;
    logic [NB-1:0]  r_num;
    logic [DB:0]    r_q;    // extra bit flags saturation
    logic [6:0]     r_dcnt;
    logic           r_dbusy;
    logic           r_sat;
    logic [SB+1:0]  w_dr_sh;
    logic [6:0]     w_dlast;

    assign w_div = (i_mode == ncvd_pkg::t_MODE_L1) ? ({1'b0, r_asum} + {1'b0, r_bsum})
                                                   : {1'b0, r_root};
    assign o_status.div_zero = (w_div == '0);
    assign w_dr_sh = {r_drem[SB:0], r_num[NB-1]};
    assign w_dlast = 7'(NB-1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
        end else if (i_cmd.div_start) begin
            r_dbusy <= 1'b1;
            r_dvs   <= w_div;
            r_num   <= (i_mode == ncvd_pkg::t_MODE_L1) ? {r_dsum, 17'd0}
                                                       : {1'b0, r_dsum, 16'd0};
            r_drem  <= '0;
            r_q     <= '0;
            r_sat   <= 1'b0;
            r_dcnt  <= '0;
        end else if (r_dbusy) begin
            r_num <= r_num << 1;
            if (w_dr_sh >= {1'b0, r_dvs}) begin
                r_drem <= w_dr_sh - {1'b0, r_dvs};
                r_q    <= {r_q[DB-1:0], 1'b1};
            end else begin
                r_drem <= w_dr_sh;
                r_q    <= {r_q[DB-1:0], 1'b0};
            end
            // a quotient bit shifted past the top means >= 2^32
            r_sat  <= r_sat | r_q[DB];
            r_dcnt <= r_dcnt + 7'd1;
            if (r_dcnt == w_dlast) r_dbusy <= 1'b0;
        end
    end
    assign o_status.div_done = r_dbusy && (r_dcnt == w_dlast);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_zero_divisor <= o_status.div_zero;
            if (o_status.div_zero) o_distance <= '0;
            else if (r_sat || r_q[DB]) o_distance <= '1;
            else o_distance <= r_q[DB-1:0];
        end
    end
endmodule

>>> rtl/ncvd_ctrl.sv
// Controller state machine: sequences accumulate, product and root (L2 only), divide, output.
// Depends on ncvd_pkg.
module ncvd_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic                   i_last,
    input  logic                   i_mode,
    input  ncvd_pkg::t_status      i_status,
    output ncvd_pkg::t_cmd         o_cmd,
    output logic                   o_valid,
    input  logic                   i_stall
);
    ncvd_pkg::t_state r_state, n_state;
    ncvd_pkg::t_state r_prev;
    logic             r_ovalid, n_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ncvd_pkg::t_ST_ACC;
            r_prev   <= ncvd_pkg::t_ST_ACC;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_prev   <= r_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && i_stall;
        o_cmd    = '0;
        o_stall  = 1'b1;
        unique case (r_state)
            ncvd_pkg::t_ST_ACC: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.acc = 1'b1;
                    if (i_last) begin
                        if (i_mode == ncvd_pkg::t_MODE_L2) begin
                            n_state = ncvd_pkg::t_ST_MUL;
                        end else begin
                            n_state = ncvd_pkg::t_ST_DIV;
                        end
                    end
                end
            end
            ncvd_pkg::t_ST_MUL: begin
                // one-shot start on entry (sums now final)
                o_cmd.mul_start = (r_prev != ncvd_pkg::t_ST_MUL);
                if (i_status.mul_done) begin
                    n_state = ncvd_pkg::t_ST_SQRT;
                    o_cmd.sqrt_start = 1'b1;
                end
            end
            ncvd_pkg::t_ST_SQRT: begin
                if (i_status.sqrt_done) n_state = ncvd_pkg::t_ST_DIV;
            end
            ncvd_pkg::t_ST_DIV: begin
                o_cmd.div_start = (r_prev != ncvd_pkg::t_ST_DIV);
                if (i_status.div_done) n_state = ncvd_pkg::t_ST_OUT;
            end
            ncvd_pkg::t_ST_OUT: begin
                if (!r_ovalid || !i_stall) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.clear    = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = ncvd_pkg::t_ST_ACC;
                end
            end
            default: n_state = ncvd_pkg::t_ST_ACC;
        endcase
    end

    assign o_valid = r_ovalid;
endmodule

>>> rtl/normalized_count_vector_distance_core.sv
// Normalized L1/L2 distance of two count vectors, one element pair a beat.
// After the last beat, o_valid follows an 81-step divide in L1, and in L2 a serial
// multiply, a 64-step root and an 81-step divide, plus any wait on a stalled result.
// Throughput: one pair a cycle until the last pair; input stalls from then until the
// result is loaded, and the load waits while the previous result is still stalled.
// Reset: synchronous, active low; clears sums, mode, state and output valid.
module normalized_count_vector_distance_core #(
    parameter int unsigned COUNT_BITS = ncvd_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_wdata,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [ncvd_pkg::FIELD_BITS-1:0] i_count_a,
    input  logic [ncvd_pkg::FIELD_BITS-1:0] i_count_b,
    input  logic                            i_last_element,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [ncvd_pkg::DIST_BITS-1:0]  o_distance,
    output logic                            o_zero_divisor
);
    logic              r_mode;
    ncvd_pkg::t_cmd    w_cmd;
    ncvd_pkg::t_status w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_mode <= 1'b0;
        else if (i_cfg_we) r_mode <= i_cfg_wdata;
    end

    ncvd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_last   (i_last_element),
        .i_mode   (r_mode),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_valid  (o_valid),
        .i_stall  (i_stall)
    );

    ncvd_datapath #(.COUNT_BITS(COUNT_BITS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_mode         (r_mode),
        .i_count_a      (i_count_a),
        .i_count_b      (i_count_b),
        .o_status       (w_status),
        .o_distance     (o_distance),
        .o_zero_divisor (o_zero_divisor)
    );
endmodule

>>> rtl/ncvd_checker.sv
// Port-level checker for the distance core, bound to the top level.
// Depends on nothing beyond the top level's ports.
module ncvd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_last_element,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_distance,
    input logic        o_zero_divisor
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_distance))
        else $error("output beat dropped while stalled");

    a_zero_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_divisor |-> o_distance == 32'd0)
        else $error("zero divisor with nonzero distance");

    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_last_element |=> o_stall)
        else $error("input taken while result computed");

    a_new_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared while accumulating");
endmodule

bind normalized_count_vector_distance_core ncvd_checker u_ncvd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .i_last_element (i_last_element),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_distance     (o_distance),
    .o_zero_divisor (o_zero_divisor)
);
